// ===== hdl/ccm_pkg.sv =====
// Shared constants and types for the cycle coloring count block.
package ccm_pkg;

  localparam int unsigned ExpBits = 64;

  localparam logic [29:0] PrimeMod = 30'd1000000007;
  localparam logic [31:0] TwoPrime = 32'd2000000014;
  localparam logic [31:0] BarrettMu =
      32'(64'h1000_0000_0000_0000 / 64'd1000000007);

  typedef struct packed {
    logic start;
    logic direct;
  } ccm_req_t;

  typedef struct packed {
    logic        done;
    logic [29:0] res;
  } ccm_rsp_t;

endpackage

// ===== hdl/ccm_modmul.sv =====
// Sequenced modular multiplier with Barrett reduction on one shared 32x32 multiplier.
module ccm_modmul
  import ccm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ccm_req_t    req_i,
  input  logic [29:0] a_i,
  input  logic [29:0] b_i,
  input  logic [59:0] x_i,
  output ccm_rsp_t    rsp_o
);

  typedef enum logic [2:0] {
    MM_IDLE,
    MM_MUL,
    MM_QMU,
    MM_QP,
    MM_SUB,
    MM_FIX
  } mm_state_e;

  mm_state_e   state_q;
  logic [59:0] x_q;
  logic [63:0] prod_q;
  logic [31:0] r_q;
  logic [29:0] res_q;
  logic        done_q;

  logic [31:0] op1;
  logic [31:0] op2;
  logic [63:0] mul_out;
  logic [31:0] fix_val;

  always_comb begin
    case (state_q)
      MM_MUL: begin
        op1 = {2'b00, a_i};
        op2 = {2'b00, b_i};
      end
      MM_QMU: begin
        op1 = {1'b0, x_q[59:29]};
        op2 = BarrettMu;
      end
      default: begin
        op1 = {1'b0, prod_q[61:31]};
        op2 = {2'b00, PrimeMod};
      end
    endcase
    mul_out = 64'(op1) * 64'(op2);
  end

  always_comb begin
    if (r_q >= TwoPrime) begin
      fix_val = r_q - TwoPrime;
    end else if (r_q >= {2'b00, PrimeMod}) begin
      fix_val = r_q - {2'b00, PrimeMod};
    end else begin
      fix_val = r_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MM_IDLE;
      done_q  <= 1'b0;
      x_q     <= '0;
      prod_q  <= '0;
      r_q     <= '0;
      res_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        MM_IDLE: begin
          if (req_i.start) begin
            if (req_i.direct) begin
              x_q     <= x_i;
              state_q <= MM_QMU;
            end else begin
              state_q <= MM_MUL;
            end
          end
        end
        MM_MUL: begin
          x_q     <= mul_out[59:0];
          state_q <= MM_QMU;
        end
        MM_QMU: begin
          prod_q  <= mul_out;
          state_q <= MM_QP;
        end
        MM_QP: begin
          prod_q  <= mul_out;
          state_q <= MM_SUB;
        end
        MM_SUB: begin
          r_q     <= x_q[31:0] - prod_q[31:0];
          state_q <= MM_FIX;
        end
        MM_FIX: begin
          res_q   <= fix_val[29:0];
          done_q  <= 1'b1;
          state_q <= MM_IDLE;
        end
        default: begin
          state_q <= MM_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

// ===== hdl/cycle_coloring_count_mod_prime_top.sv =====
// Top level: counts proper colorings of an n-cycle with k colors modulo 1000000007.
// Each modular multiplication is sequenced through the shared 32x32 multiplier in ccm_modmul.
// One transaction is processed at a time; the next is taken in the cycle after the result is
// written to the output register, where it waits while the output is stalled.
// Reset is asynchronous, active low, and clears the sequencer and the output valid.
module cycle_coloring_count_mod_prime_top
  import ccm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] cycle_length_i,
  input  logic [62:0] color_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [29:0] coloring_count_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KHI,
    ST_KLO,
    ST_STEP,
    ST_WACC,
    ST_WSQ,
    ST_FIN
  } top_state_e;

  top_state_e         state_q;
  ccm_req_t           req_q;
  ccm_rsp_t           mm_rsp;
  logic [ExpBits-1:0] n_q;
  logic               par_q;
  logic [29:0]        klo_q;
  logic [29:0]        base_q;
  logic [29:0]        acc_q;
  logic [29:0]        sq_q;
  logic [29:0]        op_a_q;
  logic [29:0]        op_b_q;
  logic [59:0]        op_x_q;
  logic [29:0]        out_q;
  logic               out_valid_q;

  logic [29:0] base_d;
  logic [30:0] final_d;
  logic [30:0] sum;

  ccm_modmul u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_q),
    .a_i    (op_a_q),
    .b_i    (op_b_q),
    .x_i    (op_x_q),
    .rsp_o  (mm_rsp)
  );

  always_comb begin
    if (mm_rsp.res == '0) begin
      base_d = PrimeMod - 30'd1;
    end else begin
      base_d = mm_rsp.res - 30'd1;
    end
    sum = {1'b0, acc_q} + {1'b0, base_q};
    if (par_q) begin
      if (acc_q >= base_q) begin
        final_d = {1'b0, acc_q} - {1'b0, base_q};
      end else begin
        final_d = {1'b0, acc_q} + {1'b0, PrimeMod} - {1'b0, base_q};
      end
    end else begin
      if (sum >= {1'b0, PrimeMod}) begin
        final_d = sum - {1'b0, PrimeMod};
      end else begin
        final_d = sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      req_q       <= '0;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      par_q       <= 1'b0;
      klo_q       <= '0;
      base_q      <= '0;
      acc_q       <= '0;
      sq_q        <= '0;
      op_a_q      <= '0;
      op_b_q      <= '0;
      op_x_q      <= '0;
      out_q       <= '0;
    end else begin
      req_q.start <= 1'b0;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            n_q     <= cycle_length_i[ExpBits-1:0];
            par_q   <= cycle_length_i[0];
            klo_q   <= color_count_i[29:0];
            op_x_q  <= 60'(color_count_i[62:30]);
            req_q   <= '{start: 1'b1, direct: 1'b1};
            state_q <= ST_KHI;
          end
        end
        ST_KHI: begin
          if (mm_rsp.done) begin
            op_x_q  <= {mm_rsp.res, klo_q};
            req_q   <= '{start: 1'b1, direct: 1'b1};
            state_q <= ST_KLO;
          end
        end
        ST_KLO: begin
          if (mm_rsp.done) begin
            base_q  <= base_d;
            sq_q    <= base_d;
            acc_q   <= 30'd1;
            state_q <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (n_q == '0) begin
            state_q <= ST_FIN;
          end else if (n_q[0]) begin
            op_a_q  <= acc_q;
            op_b_q  <= sq_q;
            req_q   <= '{start: 1'b1, direct: 1'b0};
            state_q <= ST_WACC;
          end else begin
            op_a_q  <= sq_q;
            op_b_q  <= sq_q;
            req_q   <= '{start: 1'b1, direct: 1'b0};
            state_q <= ST_WSQ;
          end
        end
        ST_WACC: begin
          if (mm_rsp.done) begin
            acc_q <= mm_rsp.res;
            if ((n_q >> 1) == '0) begin
              n_q     <= '0;
              state_q <= ST_STEP;
            end else begin
              op_a_q  <= sq_q;
              op_b_q  <= sq_q;
              req_q   <= '{start: 1'b1, direct: 1'b0};
              state_q <= ST_WSQ;
            end
          end
        end
        ST_WSQ: begin
          if (mm_rsp.done) begin
            sq_q    <= mm_rsp.res;
            n_q     <= n_q >> 1;
            state_q <= ST_STEP;
          end
        end
        ST_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q       <= final_d[29:0];
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign coloring_count_o = out_q;

endmodule

// ===== hdl/ccm_checker.sv =====
// Port-level checker for the cycle coloring count block, bound to its top level.
module ccm_checker
  import ccm_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [29:0] coloring_count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(coloring_count_o))
    else $error("Stalled result changed or dropped.");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> coloring_count_o < PrimeMod)
    else $error("Result is not reduced below the modulus.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Block did not turn busy after a transaction was taken.");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("Result appeared without a transaction in progress.");

endmodule

bind cycle_coloring_count_mod_prime_top ccm_checker u_ccm_checker (.*);
